// ===== rtl/core/kwm_pkg.sv =====
// Shared constants, types and helpers of the k-way sorted run merger.
package kwm_pkg;

  // Number of head entries kept, and field widths.
  localparam int RUNS   = 16;
  localparam int RUN_W  = $clog2(RUNS);
  localparam int WORD_W = 32;
  localparam int CNT_W  = 5;

  // The smaller of the storage depth and the largest run count the port can name.
  localparam int RUN_CAP = (RUNS < 16) ? RUNS : 16;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [RUN_W-1:0]  run_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Effective run count: zero counts as one, and the count is capped at storage.
  function automatic cnt_t eff_runs(input cnt_t num);
    cnt_t n;
    n = num;
    if (n == '0) begin
      n = cnt_t'(1);
    end
    if (n > cnt_t'(RUN_CAP)) begin
      n = cnt_t'(RUN_CAP);
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/kwm_if.sv =====
// Valid/ready channel interfaces for the input and result beats of the merger.
interface kwm_in_if
  import kwm_pkg::*;
  ();
  logic  valid;
  logic  ready;
  run_t  run_index;
  word_t word_value;
  logic  run_exhausted;

  modport source (output valid, output run_index, output word_value,
                  output run_exhausted, input ready);
  modport sink   (input valid, input run_index, input word_value,
                  input run_exhausted, output ready);
endinterface

interface kwm_out_if
  import kwm_pkg::*;
  ();
  logic  valid;
  logic  ready;
  word_t merged_value;
  run_t  source_run;
  logic  merge_done;
  logic  order_error;

  modport source (output valid, output merged_value, output source_run,
                  output merge_done, output order_error, input ready);
  modport sink   (input valid, input merged_value, input source_run,
                  input merge_done, input order_error, output ready);
endinterface

// ===== rtl/core/kwm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/k_way_sorted_run_merger.sv =====
// K-way merger of sorted runs: a head memory scanned once per result beat.
//
// The block keeps one head word per run in a small RAM and a valid bit per run
// in flip-flops. After cfg_we it waits for a load beat for each run 0..n-1 in
// order (n is num_runs, zero read as one, capped at RUNS); the last load beat
// yields the smallest head, lowest run winning ties, or a done beat. Each
// following input beat must refill or exhaust the named source run. A beat
// naming another run yields an order_error beat and changes nothing. A load
// beat that is not the last yields no result; an error beat goes straight
// to the output register; a merged or done result first passes S_SCAN and
// S_LAST, as the head RAM's one read port scans all n heads, one per cycle,
// to find the minimum. One input beat is handled at a time.
module k_way_sorted_run_merger
  import kwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  kwm_in_if.sink           in_ch,
  kwm_out_if.source        out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_OUT
  } state_t;

  state_t            state_r;
  cnt_t              num_runs_r;
  logic [RUNS-1:0]   head_valid_r;
  cnt_t              loaded_r;
  run_t              awaited_r;
  logic              merging_r;
  run_t              scan_cnt_r;
  logic              cmp_vld_r;
  run_t              cmp_idx_r;
  logic              found_r;
  word_t             best_val_r;
  run_t              best_idx_r;
  logic              out_valid_r;
  word_t             out_value_r;
  run_t              out_src_r;
  logic              out_done_r;
  logic              out_err_r;

  cnt_t              n_eff;
  cnt_t              expect_idx;
  cnt_t              idx_ext;
  cnt_t              loaded_nxt;
  logic              in_fire;
  logic              in_bad;
  logic              ram_we;
  word_t             rd_data;
  logic              take_c;
  logic              found_c;
  word_t             best_val_c;
  run_t              best_idx_c;

  assign n_eff      = eff_runs(num_runs_r);
  assign idx_ext    = cnt_t'(in_ch.run_index);
  assign expect_idx = merging_r ? cnt_t'(awaited_r) : loaded_r;
  assign loaded_nxt = loaded_r + cnt_t'(1);
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign in_bad     = (idx_ext != expect_idx) || (idx_ext >= n_eff);
  assign ram_we     = in_fire && !in_bad && !in_ch.run_exhausted;

  assign in_ch.ready = (state_r == S_IDLE);

  // Head word storage, written on a good beat, read by the scan.
  kwm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RUNS)
  ) u_heads (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.run_index),
    .wdata (in_ch.word_value),
    .raddr (scan_cnt_r),
    .rdata (rd_data)
  );

  // Running minimum over the RAM's registered read data for each scanned address.
  always_comb begin
    take_c     = cmp_vld_r && head_valid_r[cmp_idx_r] &&
                 (!found_r || (rd_data < best_val_r));
    found_c    = found_r || take_c;
    best_val_c = take_c ? rd_data : best_val_r;
    best_idx_c = take_c ? cmp_idx_r : best_idx_r;
  end

  // Sequencer, merge state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      num_runs_r   <= cnt_t'(1);
      head_valid_r <= '0;
      loaded_r     <= '0;
      awaited_r    <= '0;
      merging_r    <= 1'b0;
      scan_cnt_r   <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cfg_we) begin
            num_runs_r   <= cfg_wdata;
            head_valid_r <= '0;
            loaded_r     <= '0;
            awaited_r    <= '0;
            merging_r    <= 1'b0;
          end else if (in_fire) begin
            if (in_bad) begin
              out_valid_r <= 1'b1;
              out_value_r <= '0;
              out_src_r   <= '0;
              out_done_r  <= 1'b0;
              out_err_r   <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              head_valid_r[in_ch.run_index] <= !in_ch.run_exhausted;
              scan_cnt_r <= '0;
              cmp_vld_r  <= 1'b0;
              found_r    <= 1'b0;
              if (merging_r) begin
                state_r <= S_SCAN;
              end else begin
                loaded_r <= loaded_nxt;
                if (loaded_nxt >= n_eff) begin
                  state_r <= S_SCAN;
                end
              end
            end
          end
        end

        S_SCAN: begin
          found_r    <= found_c;
          best_val_r <= best_val_c;
          best_idx_r <= best_idx_c;
          cmp_vld_r  <= 1'b1;
          cmp_idx_r  <= scan_cnt_r;
          if (scan_cnt_r == run_t'(n_eff - cnt_t'(1))) begin
            state_r <= S_LAST;
          end else begin
            scan_cnt_r <= scan_cnt_r + run_t'(1);
          end
        end

        S_LAST: begin
          // The last head has been compared: publish the winner or finish.
          cmp_vld_r   <= 1'b0;
          out_valid_r <= 1'b1;
          out_err_r   <= 1'b0;
          if (found_c) begin
            out_value_r <= best_val_c;
            out_src_r   <= best_idx_c;
            out_done_r  <= 1'b0;
            merging_r   <= 1'b1;
            awaited_r   <= best_idx_c;
          end else begin
            out_value_r <= '0;
            out_src_r   <= '0;
            out_done_r  <= 1'b1;
            merging_r   <= 1'b0;
            loaded_r    <= '0;
            awaited_r   <= '0;
          end
          state_r <= S_OUT;
        end

        S_OUT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.merged_value = out_value_r;
  assign out_ch.source_run   = out_src_r;
  assign out_ch.merge_done   = out_done_r;
  assign out_ch.order_error  = out_err_r;

endmodule

// ===== tb/kwm_merge_checker.sv =====
// Merge checker: watches the merger's channels, predicts every result beat and compares it.
`timescale 1ns / 1ps

module kwm_merge_checker
  import kwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  kwm_in_if                in_ch,
  kwm_out_if               out_ch,
  output int               mismatch_count,
  output int               outstanding
);

  typedef struct packed {
    word_t merged_value;
    run_t  source_run;
    logic  merge_done;
    logic  order_error;
  } merge_beat_t;

  // Predicted copy of the block's state.
  word_t head_word [RUNS];
  bit    head_live [RUNS];
  cnt_t  loads_seen;
  run_t  refill_run;
  bit    merging;
  cnt_t  run_setting;

  // Result beats predicted but not yet seen, oldest first.
  merge_beat_t merge_results_due [$];

  // Number of runs really taking part: zero counts as one, capped at storage.
  function automatic int live_runs();
    int n;
    n = int'(run_setting);
    if (n == 0) begin
      n = 1;
    end
    if (n > RUN_CAP) begin
      n = RUN_CAP;
    end
    return n;
  endfunction

  // Pick the smallest live head (lowest run on ties), or finish the merge.
  function automatic merge_beat_t smallest_head();
    merge_beat_t res;
    int best;
    best = -1;
    res = '0;
    for (int i = 0; i < live_runs(); i++) begin
      if (head_live[i] && (best < 0 || head_word[i] < head_word[best])) begin
        best = i;
      end
    end
    if (best < 0) begin
      merging = 1'b0;
      loads_seen = '0;
      refill_run = '0;
      res.merge_done = 1'b1;
    end else begin
      merging = 1'b1;
      refill_run = run_t'(best);
      res.merged_value = head_word[best];
      res.source_run = run_t'(best);
    end
    return res;
  endfunction

  // Apply one accepted input beat and queue the result it causes, if any.
  function automatic void take_input(input run_t idx, input word_t word, input logic ex);
    merge_beat_t res;
    int awaited;
    awaited = merging ? int'(refill_run) : int'(loads_seen);
    res = '0;
    if (int'(idx) != awaited || int'(idx) >= RUNS || int'(idx) >= live_runs()) begin
      res.order_error = 1'b1;
      merge_results_due = {merge_results_due, res};
    end else begin
      head_live[idx] = !ex;
      if (!ex) begin
        head_word[idx] = word;
      end
      if (merging) begin
        res = smallest_head();
        merge_results_due = {merge_results_due, res};
      end else begin
        loads_seen = loads_seen + 1'b1;
        if (int'(loads_seen) >= live_runs()) begin
          res = smallest_head();
          merge_results_due = {merge_results_due, res};
        end
      end
    end
  endfunction

  // Compare one result beat with the oldest prediction, field by field.
  function automatic void check_result();
    merge_beat_t want;
    if (merge_results_due.size() == 0) begin
      $error("result beat with nothing predicted: merged_value %08h source_run %0d",
             out_ch.merged_value, out_ch.source_run);
      mismatch_count++;
    end else begin
      want = merge_results_due.pop_front();
      if (out_ch.merged_value !== want.merged_value) begin
        $error("merged_value: expected %08h, got %08h", want.merged_value, out_ch.merged_value);
        mismatch_count++;
      end
      if (out_ch.source_run !== want.source_run) begin
        $error("source_run: expected %0d, got %0d", want.source_run, out_ch.source_run);
        mismatch_count++;
      end
      if (out_ch.merge_done !== want.merge_done) begin
        $error("merge_done: expected %0b, got %0b", want.merge_done, out_ch.merge_done);
        mismatch_count++;
      end
      if (out_ch.order_error !== want.order_error) begin
        $error("order_error: expected %0b, got %0b", want.order_error, out_ch.order_error);
        mismatch_count++;
      end
    end
  endfunction

  // Track the block on every rising edge; results are compared before new inputs are applied.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RUNS; i++) begin
        head_word[i] = '0;
        head_live[i] = 1'b0;
      end
      loads_seen = '0;
      refill_run = '0;
      merging = 1'b0;
      run_setting = cnt_t'(1);
      merge_results_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_result();
      end
      if (in_ch.valid && in_ch.ready) begin
        take_input(in_ch.run_index, in_ch.word_value, in_ch.run_exhausted);
      end
      // A register write drops any merge or load in progress.
      if (cfg_we) begin
        run_setting = cfg_wdata;
        for (int i = 0; i < RUNS; i++) begin
          head_live[i] = 1'b0;
        end
        loads_seen = '0;
        refill_run = '0;
        merging = 1'b0;
      end
    end
    outstanding = merge_results_due.size();
  end

endmodule

// ===== tb/tb_k_way_sorted_run_merger.sv =====
// Testbench top of the k-way merger: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 1ps

module tb_k_way_sorted_run_merger;
  import kwm_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_BEATS  = 1200;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  kwm_in_if  in_ch ();
  kwm_out_if out_ch ();

  int mismatch_count;
  int outstanding;
  int cycle_count = 0;
  int beats_sent = 0;
  int run_total = 1;
  bit no_stalls = 1'b0;

  k_way_sorted_run_merger dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  kwm_merge_checker merge_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle limit against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result sink: before each beat it holds ready low for a random number of cycles.
  initial begin : result_sink
    int hold;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = no_stalls ? 0 : $urandom_range(19);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // Drive one input beat after a random gap; valid stays high for a following beat.
  task automatic send_beat(input int idx, input word_t word, input bit ex);
    int gap;
    gap = no_stalls ? 0 : $urandom_range(19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.run_index <= run_t'(idx);
    in_ch.word_value <= word;
    in_ch.run_exhausted <= ex;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    beats_sent++;
  endtask

  // Stop sending, wait for every predicted result, then let a silent load beat finish.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write the run count; only called while the block is idle.
  task automatic write_run_count(input int value);
    cfg_wdata <= cnt_t'(value);
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    run_total = (value == 0) ? 1 : (value > RUN_CAP) ? RUN_CAP : value;
  endtask

  // First word of a run, weighted toward the extremes.
  function automatic word_t first_word();
    case ($urandom_range(5))
      0: return '0;
      1: return word_t'(32'hFFFF_FFFF - $urandom_range(7));
      2: return word_t'($urandom);
      default: return word_t'($urandom >> $urandom_range(31));
    endcase
  endfunction

  // Next word of an ascending run: a repeat, a small step or a big one, saturating at the top.
  function automatic word_t next_word(input word_t prev);
    logic [WORD_W:0] sum;
    case ($urandom_range(3))
      0: sum = {1'b0, prev};
      1: sum = {1'b0, prev} + (WORD_W+1)'($urandom_range(3));
      default: sum = {1'b0, prev} + (WORD_W+1)'($urandom >> $urandom_range(31));
    endcase
    return sum[WORD_W] ? '1 : sum[WORD_W-1:0];
  endfunction

  // Now and then send a beat naming the wrong run.
  task automatic stray_beat(input int awaited);
    int idx;
    if ($urandom_range(7) == 0) begin
      idx = $urandom_range(15);
      if (idx == awaited) begin
        idx = (idx + 1) % 16;
      end
      send_beat(idx, word_t'($urandom), bit'($urandom_range(1)));
    end
  endtask

  // One well-formed merge of random ascending runs; it may be cut short for an abort.
  task automatic merge_runs(input bit noisy, input bit cut_short);
    word_t head [RUNS];
    bit    live [RUNS];
    int    left [RUNS];
    int    best;
    int    r;
    for (r = 0; r < run_total; r++) begin
      left[r] = ($urandom_range(11) == 0) ? $urandom_range(20) : $urandom_range(6);
      live[r] = (left[r] > 0);
      head[r] = live[r] ? first_word() : word_t'($urandom);
      if (live[r]) begin
        left[r]--;
      end
    end
    // Load phase: one head or exhausted mark per run, in run order.
    for (r = 0; r < run_total; r++) begin
      if (cut_short && $urandom_range(15) == 0) begin
        return;
      end
      if (noisy) begin
        stray_beat(r);
      end
      send_beat(r, head[r], !live[r]);
    end
    // Merge phase: refill whichever run the block just took from.
    while (1'b1) begin
      best = -1;
      for (r = 0; r < run_total; r++) begin
        if (live[r] && (best < 0 || head[r] < head[best])) begin
          best = r;
        end
      end
      if (best < 0) begin
        break;
      end
      if (cut_short && $urandom_range(7) == 0) begin
        break;
      end
      if (noisy) begin
        stray_beat(best);
      end
      if (left[best] > 0) begin
        head[best] = next_word(head[best]);
        left[best]--;
      end else begin
        live[best] = 1'b0;
      end
      send_beat(best, live[best] ? head[best] : word_t'($urandom), !live[best]);
    end
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    int setting;
    int merges;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.run_index = '0;
    in_ch.word_value = '0;
    in_ch.run_exhausted = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: the reset run count, largest word, then exhausting the only run.
    send_beat(0, 32'hFFFF_FFFF, 1'b0);
    send_beat(0, '0, 1'b1);
    // A load beat naming a run beyond the count.
    send_beat(5, '0, 1'b0);
    // A count of zero acts as one; a lone exhausted run ends at once.
    wait_idle();
    write_run_count(0);
    send_beat(0, word_t'($urandom), 1'b1);
    // Largest setting is capped at sixteen runs; a tie goes to the lower run.
    wait_idle();
    write_run_count(31);
    for (int r = 0; r < 16; r++) begin
      if (r == 3 || r == 7) begin
        send_beat(r, '0, 1'b0);
      end else if (r == 10) begin
        send_beat(r, 32'h8000_0000, 1'b0);
      end else begin
        send_beat(r, 32'hFFFF_FFFF, r == 15);
      end
    end
    send_beat(7, '0, 1'b0);
    send_beat(3, '0, 1'b1);
    // Rewrite in mid merge, then a merge of nothing but exhausted runs.
    wait_idle();
    write_run_count(2);
    send_beat(0, word_t'($urandom), 1'b1);
    send_beat(1, word_t'($urandom), 1'b1);

    // Random phases: a new run count, then merges, sometimes noisy, sometimes cut short.
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      wait_idle();
      no_stalls = ($urandom_range(4) == 0);
      case ($urandom_range(7))
        0: setting = 0;
        1: setting = $urandom_range(17, 31);
        2: setting = 16;
        3: setting = $urandom_range(31);
        default: setting = $urandom_range(1, 6);
      endcase
      write_run_count(setting);
      if ($urandom_range(9) == 0) begin
        // Loose beats with random fields, mostly rejected.
        repeat ($urandom_range(10, 30)) begin
          send_beat($urandom_range(1) ? $urandom_range(run_total - 1) : $urandom_range(15),
                    word_t'($urandom), bit'($urandom_range(1)));
        end
      end else begin
        merges = $urandom_range(1, 3);
        for (int m = 0; m < merges; m++) begin
          merge_runs($urandom_range(2) == 0, ($urandom_range(5) == 0) && (m == merges - 1));
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
